/* sv/hashed_message_dedup_cache_core_assert.svh */
// Assertion macros shared by the dedup cache RTL.
// Both macros expect signals named clock and reset in the enclosing module.
`ifndef HASHED_MESSAGE_DEDUP_CACHE_CORE_ASSERT_SVH
`define HASHED_MESSAGE_DEDUP_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HMDC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define HMDC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hmdc_pkg.sv */
// ----------------------------------------------------------------------------
// hmdc_pkg
// Shared constants, codes and types for the hashed message dedup cache.
// ----------------------------------------------------------------------------
package hmdc_pkg;

   // FNV-1a 32-bit constants
   localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME    = 32'd16777619;

   // expiry register reset value in ms
   localparam logic [31:0] EXPIRY_RESET = 32'd60000;

   // default cache size
   localparam int CACHE_ENTRIES_DEF = 16;

   // one cache entry in RAM: {hash, timestamp}
   localparam int HASH_W  = 32;
   localparam int TIME_W  = 32;
   localparam int ENTRY_W = HASH_W + TIME_W;

   // result field widths
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // input mode codes
   localparam logic MODE_BYTE  = 1'b0;
   localparam logic MODE_SWEEP = 1'b1;

   // result kind codes
   localparam logic KIND_VERDICT = 1'b0;
   localparam logic KIND_SWEEP   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one FNV-1a step: xor the byte in, multiply by the prime mod 2^32
   function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
      logic [31:0] x;
      logic [31:0] p;
      x = h ^ {24'd0, b};
      p = x * FNV_PRIME;
      return p;
   endfunction

endpackage

/* sv/hmdc_ram.sv */
// ----------------------------------------------------------------------------
// hmdc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hmdc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/hashed_message_dedup_cache_core.sv */
// Non-final message byte: taken with no result.
// Final byte or sweep: result valid after a scan of one RAM read per entry; the next item
//   is not taken until that result has been loaded into the result register.
// Reset (synchronous): all entries invalid at once, no clearing pass; hash back to the
//   offset basis; expiry_ms = 60000.
// ----------------------------------------------------------------------------
// hashed_message_dedup_cache_core
// FNV-1a message hashing with a small duplicate cache. Entries (hash, time)
// live in one RAM and are scanned one per cycle; valid bits are flip-flops.
// ----------------------------------------------------------------------------
module hashed_message_dedup_cache_core
   import hmdc_pkg::*;
#(
   parameter int CACHE_ENTRIES = CACHE_ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // item input
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   input  logic [TIME_W-1:0]   req_now_ms,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic                rsp_is_duplicate,
   output logic [HASH_W-1:0]   rsp_message_hash,
   output logic [SLOT_W-1:0]   rsp_stored_slot,
   output logic [COUNT_W-1:0]  rsp_expired_count,
   // configuration
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);

   `include "hashed_message_dedup_cache_core_assert.svh"

   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CACHE_ENTRIES);

   // control
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;

   // per-item working registers
   logic [HASH_W-1:0]    run_hash_ff, run_hash_in;
   logic [HASH_W-1:0]    msg_hash_ff, msg_hash_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 kind_ff, kind_in;
   logic                 hit_ff, hit_in;
   logic                 free_ff, free_in;
   logic [TIME_W-1:0]    oldest_ff, oldest_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [31:0]          expiry_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic                 rsp_dup_ff, rsp_dup_in;
   logic [HASH_W-1:0]    rsp_hash_ff, rsp_hash_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                 ram_wr_en;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   // helpers
   logic                 req_take;
   logic                 rsp_free;
   logic                 finish_go;
   logic [HASH_W-1:0]    byte_hash;
   logic [HASH_W-1:0]    ent_hash;
   logic [TIME_W-1:0]    ent_time;
   logic                 ent_valid;
   logic [TIME_W-1:0]    ent_age;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign finish_go = (state_ff == ST_FINISH) && rsp_free;
   assign byte_hash = fnv_step(run_hash_ff, req_data_byte);

   assign ent_hash  = ram_rd_data[ENTRY_W-1:TIME_W];
   assign ent_time  = ram_rd_data[TIME_W-1:0];
   assign ent_valid = valid_ff[cmp_idx_ff];
   assign ent_age   = now_ff - ent_time;
   assign slot_ext  = {{SLOT_W{1'b0}}, slot_ff};

   // entry store
   hmdc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CACHE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_mode == MODE_SWEEP || req_last_byte)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and RAM controls
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      ram_rd_en   = (state_ff == ST_SCAN) && (cnt_ff != CNT_LAST);
      ram_rd_addr = cnt_ff[IDX_W-1:0];
      ram_wr_en   = finish_go && (kind_ff == KIND_VERDICT) && !hit_ff;
      ram_wr_data = {msg_hash_ff, now_ff};
   end

   // datapath next values
   always_comb begin
      run_hash_in = run_hash_ff;
      msg_hash_in = msg_hash_ff;
      now_in      = now_ff;
      kind_in     = kind_ff;
      hit_in      = hit_ff;
      free_in     = free_ff;
      oldest_in   = oldest_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      cnt_in      = cnt_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      valid_in    = valid_ff;

      // item intake: fold bytes, start a scan on last byte or sweep
      if (req_take) begin
         now_in    = req_now_ms;
         hit_in    = 1'b0;
         free_in   = 1'b0;
         oldest_in = req_now_ms;
         slot_in   = '0;
         count_in  = '0;
         cnt_in    = '0;
         if (req_mode == MODE_SWEEP) begin
            kind_in = KIND_SWEEP;
         end else begin
            kind_in = KIND_VERDICT;
            if (req_last_byte) begin
               msg_hash_in = byte_hash;
               run_hash_in = FNV_BASIS;
            end else begin
               run_hash_in = byte_hash;
            end
         end
      end

      // scan: issue one read a cycle, compare the entry read last cycle
      if (state_ff == ST_SCAN) begin
         if (cnt_ff != CNT_LAST) begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = cnt_ff[IDX_W-1:0];
            cnt_in     = cnt_ff + CNT_W'(1);
         end
         if (cmp_vld_ff) begin
            if (kind_ff == KIND_SWEEP) begin
               if (ent_valid && (ent_age > expiry_ff)) begin
                  valid_in[cmp_idx_ff] = 1'b0;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
               end
            end else begin
               if (ent_valid && (ent_hash == msg_hash_ff)) begin
                  hit_in = 1'b1;
               end
               // victim: first free slot, else oldest stamp below now
               if (!free_ff) begin
                  if (!ent_valid) begin
                     free_in = 1'b1;
                     slot_in = cmp_idx_ff;
                  end else if (ent_time < oldest_ff) begin
                     oldest_in = ent_time;
                     slot_in   = cmp_idx_ff;
                  end
               end
            end
         end
      end

      // miss: claim the chosen slot
      if (ram_wr_en) begin
         valid_in[slot_ff] = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         if (kind_ff == KIND_SWEEP) begin
            rsp_dup_in   = 1'b0;
            rsp_hash_in  = '0;
            rsp_slot_in  = '0;
            rsp_count_in = count_ff;
         end else begin
            rsp_dup_in   = hit_ff;
            rsp_hash_in  = msg_hash_ff;
            rsp_slot_in  = hit_ff ? '0 : slot_ext[SLOT_W-1:0];
            rsp_count_in = '0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         run_hash_ff  <= FNV_BASIS;
         expiry_ff    <= EXPIRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         run_hash_ff  <= run_hash_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expiry_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      msg_hash_ff  <= msg_hash_in;
      now_ff       <= now_in;
      kind_ff      <= kind_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      oldest_ff    <= oldest_in;
      slot_ff      <= slot_in;
      count_ff     <= count_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_kind_ff;
   assign rsp_is_duplicate  = rsp_dup_ff;
   assign rsp_message_hash  = rsp_hash_ff;
   assign rsp_stored_slot   = rsp_slot_ff;
   assign rsp_expired_count = rsp_count_ff;

   // checks
   `HMDC_ASSERT_IMP(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH,
      "result loaded outside the finish state")
   `HMDC_ASSERT_IMP(a_no_write_in_scan, ram_wr_en, !cmp_vld_ff && !ram_rd_en,
      "entry write overlaps a scan access")
   `HMDC_ASSERT_IMP(a_cmp_in_scan, cmp_vld_ff, state_ff == ST_SCAN,
      "entry compare outside the scan")
   `HMDC_ASSERT_NXT(a_scan_ends, (state_ff == ST_SCAN) && (cnt_ff == CNT_LAST),
      state_ff == ST_FINISH && !cmp_vld_ff, "scan did not hand over to finish")

endmodule

/* dv/hashed_message_dedup_cache_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_message_dedup_cache_core_tb
// Self-checking bench for the FNV-1a duplicate filter. A shadow copy of the
// hash, the cache and the expiry limit predicts every verdict and sweep
// result. A directed opening is followed by random phases, each under its own
// expiry setting, with random idling on both sides of the block.
// ----------------------------------------------------------------------------
module hashed_message_dedup_cache_core_tb;
   import hmdc_pkg::*;

   localparam int CACHE_SLOTS = CACHE_ENTRIES_DEF;
   localparam int PHASE_ITEMS = 115;
   localparam int LONG_HOLD   = 400;
   localparam int LIB_DEPTH   = 24;
   localparam int MSG_MAX     = 8;

   // one expected result item
   typedef struct packed {
      logic               kind;
      logic               dup;
      logic [HASH_W-1:0]  hash;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] count;
   } dedup_result_type;

   // Shadow of the hash and cache; predicts results and checks them in order
   class dedup_cache_shadow;
      logic [31:0]       age_limit;
      logic [31:0]       fold;
      logic [31:0]       slot_hash [CACHE_SLOTS];
      logic [31:0]       slot_time [CACHE_SLOTS];
      bit                slot_live [CACHE_SLOTS];
      dedup_result_type  pending_verdicts [$];
      int                mismatches;

      function new();
         age_limit  = EXPIRY_RESET;
         fold       = FNV_BASIS;
         mismatches = 0;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction

      // an accepted input item
      function void take_item(logic mode, logic [7:0] data, logic last, logic [31:0] now);
         dedup_result_type r;
         logic [31:0]      oldest;
         int               slot;
         bit               found;
         r = '0;
         if (mode == MODE_SWEEP) begin
            // drop anything older than the limit; ages wrap modulo 2^32
            r.kind = KIND_SWEEP;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
               if (slot_live[i] && (now - slot_time[i]) > age_limit) begin
                  slot_live[i] = 1'b0;
                  if (r.count < COUNT_MAX) r.count = r.count + 1'b1;
               end
            end
            pending_verdicts.push_back(r);
            return;
         end
         fold = (fold ^ {24'd0, data}) * FNV_PRIME;
         if (!last) return;
         r.kind = KIND_VERDICT;
         r.hash = fold;
         fold   = FNV_BASIS;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            if (slot_live[i] && slot_hash[i] == r.hash) r.dup = 1'b1;
         end
         if (!r.dup) begin
            // first free slot, else the oldest stamp below now, else slot 0
            slot   = 0;
            oldest = now;
            found  = 1'b0;
            for (int i = 0; i < CACHE_SLOTS; i++) begin
               if (!found) begin
                  if (!slot_live[i]) begin
                     slot  = i;
                     found = 1'b1;
                  end else if (slot_time[i] < oldest) begin
                     oldest = slot_time[i];
                     slot   = i;
                  end
               end
            end
            slot_hash[slot] = r.hash;
            slot_time[slot] = now;
            slot_live[slot] = 1'b1;
            r.slot = SLOT_W'(slot);
         end
         pending_verdicts.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      // an accepted result item, against the oldest expectation
      function void match_result(logic kind, logic dup, logic [HASH_W-1:0] hash,
                                 logic [SLOT_W-1:0] slot, logic [COUNT_W-1:0] count);
         dedup_result_type want;
         if (pending_verdicts.size() == 0) begin
            $error("result item with nothing awaited: kind %0d hash 0x%08h", kind, hash);
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         compare_field("result_kind", 32'(want.kind), 32'(kind));
         compare_field("is_duplicate", 32'(want.dup), 32'(dup));
         compare_field("message_hash", want.hash, hash);
         compare_field("stored_slot", 32'(want.slot), 32'(slot));
         compare_field("expired_count", 32'(want.count), 32'(count));
      endfunction
   endclass

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_stall;
   logic                req_mode          = MODE_BYTE;
   logic [7:0]          req_data_byte     = 8'd0;
   logic                req_last_byte     = 1'b0;
   logic [TIME_W-1:0]   req_now_ms        = '0;
   logic                rsp_valid;
   logic                rsp_stall         = 1'b0;
   logic                rsp_result_kind;
   logic                rsp_is_duplicate;
   logic [HASH_W-1:0]   rsp_message_hash;
   logic [SLOT_W-1:0]   rsp_stored_slot;
   logic [COUNT_W-1:0]  rsp_expired_count;
   logic                csr_wr_en         = 1'b0;
   logic [31:0]         csr_wr_data       = 32'd0;

   dedup_cache_shadow   ledger = new();
   logic                calm_spell   = 1'b0;
   bit                  hold_pending = 1'b0;
   logic [31:0]         wall_ms      = 32'd0;

   // recent messages, replayed to provoke duplicates
   logic [7:0]          lib_bytes [LIB_DEPTH][MSG_MAX];
   int                  lib_len   [LIB_DEPTH];
   int                  lib_count = 0;
   int                  lib_next  = 0;

   hashed_message_dedup_cache_core #(
      .CACHE_ENTRIES (CACHE_SLOTS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_is_duplicate  (rsp_is_duplicate),
      .rsp_message_hash  (rsp_message_hash),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_expired_count (rsp_expired_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // now and then a spell with no idling on either side
   always begin
      repeat (256) @(posedge clock);
      calm_spell <= ($urandom_range(0, 3) == 0);
   end

   // idle length: mostly none or short, a few long
   function automatic int idle_len();
      int r;
      if (calm_spell) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(15, 60);
   endfunction

   // result side pacing, including the long hold-off
   initial begin : rsp_pacing
      int n;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         n = idle_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.match_result(rsp_result_kind, rsp_is_duplicate, rsp_message_hash,
                             rsp_stored_slot, rsp_expired_count);
      end
   end

   // drop valid and idle
   task automatic pause(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // offer one item, wait for it to be taken, then maybe idle
   task automatic send_item(input logic mode, input logic [7:0] data, input logic last,
                            input logic [31:0] now);
      int gap;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= data;
      req_last_byte <= last;
      req_now_ms    <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.take_item(mode, data, last, now);
      gap = idle_len();
      if (gap > 0) pause(gap);
   endtask

   // wait until every result is in and the block has settled
   task automatic wait_idle();
      pause(1);
      while (ledger.outstanding() > 0) @(posedge clock);
      repeat (CACHE_SLOTS + 4) @(posedge clock);
   endtask

   function automatic void advance_wall(input int step_max, input bit scatter);
      if (scatter) wall_ms = $urandom();
      else wall_ms = wall_ms + $urandom_range(0, step_max);
   endfunction

   // one random phase under a given expiry limit
   task automatic run_phase(input logic [31:0] expiry, input int step_max,
                            input bit scatter, input bit squeeze);
      logic [7:0] msg [MSG_MAX];
      int         len;
      int         pick;
      int         sent;
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= expiry;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      ledger.age_limit = expiry;
      if (squeeze) hold_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         // replay a recent message or make a fresh one
         if (lib_count > 0 && $urandom_range(0, 99) < 40) begin
            pick = $urandom_range(0, lib_count - 1);
            len  = lib_len[pick];
            msg  = lib_bytes[pick];
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MSG_MAX)
                                             : $urandom_range(1, 4);
            for (int k = 0; k < MSG_MAX; k++) msg[k] = 8'($urandom_range(0, 255));
            lib_bytes[lib_next] = msg;
            lib_len[lib_next]   = len;
            lib_next = (lib_next + 1) % LIB_DEPTH;
            if (lib_count < LIB_DEPTH) lib_count++;
         end
         for (int k = 0; k < len; k++) begin
            // sweeps land anywhere, mid-message too
            if ($urandom_range(0, 99) < 8) begin
               advance_wall(step_max, scatter);
               send_item(MODE_SWEEP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         wall_ms);
               sent++;
            end
            advance_wall(step_max, scatter);
            send_item(MODE_BYTE, msg[k], (k == len - 1), wall_ms);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed opening under the reset expiry of 60000 ms
      send_item(MODE_BYTE, 8'h00, 1'b1, 32'd0);           // fresh message, slot 0
      send_item(MODE_BYTE, 8'h00, 1'b1, 32'd10);          // same hash: duplicate
      send_item(MODE_BYTE, 8'hFF, 1'b0, 32'd20);          // three-byte message
      send_item(MODE_BYTE, 8'h80, 1'b0, 32'd20);
      send_item(MODE_BYTE, 8'h01, 1'b1, 32'd30);
      send_item(MODE_SWEEP, 8'hFF, 1'b1, 32'd60000);      // age equal to limit: kept
      send_item(MODE_BYTE, 8'hAA, 1'b0, 32'd60001);
      send_item(MODE_SWEEP, 8'h00, 1'b0, 32'd60001);      // mid-message, slot 0 expires
      send_item(MODE_BYTE, 8'h55, 1'b1, 32'd60002);       // message resumes, reuses slot 0
      send_item(MODE_SWEEP, 8'h5A, 1'b0, 32'hFFFF_FFFF);  // everything left expires
      send_item(MODE_BYTE, 8'h00, 1'b1, 32'hFFFF_FFFF);   // expired, so a miss again
      send_item(MODE_SWEEP, 8'hA5, 1'b1, 32'd100);        // wrapped age of 101: kept
      send_item(MODE_BYTE, 8'h00, 1'b1, 32'd200);         // still cached: duplicate

      // random phases; time starts just short of the wrap
      wall_ms = 32'hFFFF_FFC0;
      run_phase(32'd1, 3, 1'b0, 1'b0);
      run_phase(32'hFFFF_FFFF, 0, 1'b1, 1'b0);
      run_phase(32'd5000, 2000, 1'b0, 1'b1);
      run_phase($urandom_range(1, 100000), 30000, 1'b0, 1'b0);
      run_phase(32'h8000_0000, 0, 1'b1, 1'b0);
      run_phase(32'd200, 100, 1'b0, 1'b1);
      wait_idle();

      if (ledger.mismatches == 0) begin
         $display("hashed_message_dedup_cache_core_tb: done, clean");
      end else begin
         $display("hashed_message_dedup_cache_core_tb: done, errors");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #6_000_000;
      $display("hashed_message_dedup_cache_core_tb: done, errors");
      $finish;
   end

endmodule
